// ----- src/utcl_pkg.sv -----
`timescale 1ns / 1ps

package utcl_pkg;

  // Day counts since 1970-01-01 that bound the supported years 2000..2199.
  localparam logic [16:0] DaysFirstValid = 17'd10957;  // 2000-01-01
  localparam logic [16:0] DaysPastValid  = 17'd84006;  // 2200-01-01

  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [12:0] StdOffset   = 13'd3600;
  localparam logic [12:0] DstOffset   = 13'd7200;
  localparam logic [19:0] EpochShift  = 20'd719468;
  localparam logic [19:0] DaysPerEra  = 20'd146097;
  localparam logic [17:0] LastDoe     = 18'd146096;

  // Month codes used by the daylight saving rule.
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonMar = 4'd3;
  localparam logic [3:0] MonApr = 4'd4;
  localparam logic [3:0] MonSep = 4'd9;
  localparam logic [3:0] MonOct = 4'd10;

  // Classified timestamp handed from the front end to the back end.
  typedef struct packed {
    logic [16:0] days;    // UTC day count since the epoch
    logic [16:0] sod;     // UTC second of day
    logic [2:0]  wd;      // weekday, 0 is Sunday
    logic        utc_ok;  // UTC year lies in the supported range
  } utcl_item_t;

endpackage

// ----- src/utcl_fifo.sv -----
`timescale 1ns / 1ps

module utcl_fifo import utcl_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  utcl_item_t item_in,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output utcl_item_t item_out
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utcl_item_t    mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign item_out = mem_r[rd_r];

  // Pointer and occupancy updates.
  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= item_in;
    end
  end

endmodule

// ----- src/utcl_front.sv -----
`timescale 1ns / 1ps

module utcl_front import utcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [32:0] in_utc_seconds,
  input  logic        q_full,
  output logic        q_push,
  output utcl_item_t  q_item
);

  // Reciprocals for exact division by constants.
  localparam longint unsigned M675 = ((64'd1 << 36) + 64'd674) / 64'd675;
  localparam longint unsigned M7   = ((64'd1 << 20) + 64'd6) / 64'd7;

  logic        en;
  logic        v1_r, v2_r, v3_r;
  logic [16:0] tlo1_r, days1_r;
  logic [16:0] days2_r, sod2_r, x2_r;
  logic [14:0] q2_r;
  utcl_item_t  it3_r;
  logic [52:0] p675;
  logic [33:0] day_secs;
  logic [16:0] x1;
  logic [34:0] p7;
  logic [16:0] q7x;

  // The whole front pipeline moves while the queue has room.
  assign en       = !q_full;
  assign in_ready = en;
  assign q_push   = en && v3_r;
  assign q_item   = it3_r;

  // Day count is t / 86400, taken as (t >> 7) / 675.
  assign p675     = 53'(in_utc_seconds[32:7]) * 53'(M675);
  assign day_secs = 34'(days1_r) * 34'(SecsPerDay);
  assign x1       = days1_r + 17'd4;
  assign p7       = 35'(x1) * 35'(M7);
  assign q7x      = 17'({2'b00, q2_r} * 17'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage one: day count.
      tlo1_r  <= in_utc_seconds[16:0];
      days1_r <= p675[36 +: 17];
      // Stage two: second of day and weekday quotient.
      days2_r <= days1_r;
      sod2_r  <= tlo1_r - day_secs[16:0];
      x2_r    <= x1;
      q2_r    <= p7[20 +: 15];
      // Stage three: weekday and range classification.
      it3_r.days   <= days2_r;
      it3_r.sod    <= sod2_r;
      it3_r.wd     <= 3'(x2_r - q7x);
      it3_r.utc_ok <= (days2_r >= DaysFirstValid) && (days2_r < DaysPastValid);
    end
  end

endmodule

// ----- src/utcl_date.sv -----
`timescale 1ns / 1ps

module utcl_date import utcl_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] days_in,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);

  localparam longint unsigned M1460  = ((64'd1 << 29) + 64'd1459) / 64'd1460;
  localparam longint unsigned M36524 = ((64'd1 << 34) + 64'd36523) / 64'd36524;
  localparam longint unsigned M365   = ((64'd1 << 27) + 64'd364) / 64'd365;
  localparam longint unsigned M100   = ((64'd1 << 16) + 64'd99) / 64'd100;
  localparam longint unsigned M153   = ((64'd1 << 19) + 64'd152) / 64'd153;
  localparam longint unsigned M5     = ((64'd1 << 14) + 64'd4) / 64'd5;

  logic [19:0] z, era_base;
  logic [2:0]  era;
  logic [2:0]  era1_r, era2_r, era3_r, era4_r, era5_r, era6_r;
  logic [17:0] doe1_r, doe2_r, doe3_r, doe4_r;
  logic [6:0]  a2_r;
  logic [2:0]  b2_r;
  logic        c2_r;
  logic [17:0] n3_r;
  logic [8:0]  yoe4_r, yoe5_r, yoe6_r;
  logic [8:0]  doy5_r, doy6_r;
  logic [3:0]  mp6_r;
  logic [36:0] pa, pb, py;
  logic [18:0] pc;
  logic [17:0] yday;
  logic [10:0] x153, x5;
  logic [22:0] pm, pd;
  logic [3:0]  mon;
  logic [11:0] year_nxt;

  // Era selection by comparison against whole eras.
  assign z = 20'(days_in) + EpochShift;
  always_comb begin
    if (z >= 20'(5 * 146097))      era = 3'd5;
    else if (z >= 20'(4 * 146097)) era = 3'd4;
    else if (z >= 20'(3 * 146097)) era = 3'd3;
    else if (z >= 20'(2 * 146097)) era = 3'd2;
    else if (z >= DaysPerEra)      era = 3'd1;
    else                           era = 3'd0;
    era_base = 20'(era * DaysPerEra);
  end

  assign pa   = 37'(doe1_r) * 37'(M1460);
  assign pb   = 37'(doe1_r) * 37'(M36524);
  assign py   = 37'(n3_r) * 37'(M365);
  assign pc   = 19'(yoe4_r) * 19'(M100);
  assign yday = 18'(yoe4_r) * 18'd365 + 18'(yoe4_r[8:2]) - 18'(pc[16 +: 3]);
  assign x153 = 11'(doy5_r) * 11'd5 + 11'd2;
  assign pm   = 23'(x153) * 23'(M153);
  assign x5   = 11'(mp6_r) * 11'd153 + 11'd2;
  assign pd   = 23'(x5) * 23'(M5);
  assign mon  = (mp6_r < 4'd10) ? mp6_r + 4'd3 : mp6_r - 4'd9;
  assign year_nxt = 12'(yoe6_r) + 12'(era6_r) * 12'd400 + ((mon <= MonFeb) ? 12'd1 : 12'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage one: era and day of era.
      era1_r <= era;
      doe1_r <= 18'(z - era_base);
      // Stage two: leap corrections.
      era2_r <= era1_r;
      doe2_r <= doe1_r;
      a2_r   <= pa[29 +: 7];
      b2_r   <= pb[34 +: 3];
      c2_r   <= (doe1_r == LastDoe);
      // Stage three: corrected day count.
      era3_r <= era2_r;
      doe3_r <= doe2_r;
      n3_r   <= doe2_r - 18'(a2_r) + 18'(b2_r) - 18'(c2_r);
      // Stage four: year of era.
      era4_r <= era3_r;
      doe4_r <= doe3_r;
      yoe4_r <= py[27 +: 9];
      // Stage five: day of the March-based year.
      era5_r <= era4_r;
      yoe5_r <= yoe4_r;
      doy5_r <= 9'(doe4_r - yday);
      // Stage six: March-based month.
      era6_r <= era5_r;
      yoe6_r <= yoe5_r;
      doy6_r <= doy5_r;
      mp6_r  <= pm[19 +: 4];
      // Stage seven: calendar date.
      month  <= mon;
      day    <= 5'(doy6_r - pd[14 +: 9] + 9'd1);
      year   <= year_nxt;
    end
  end

endmodule

// ----- src/utcl_back.sv -----
`timescale 1ns / 1ps

module utcl_back import utcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  output logic        q_pop,
  input  utcl_item_t  q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [11:0] out_civil_year,
  output logic [3:0]  out_civil_month,
  output logic [4:0]  out_civil_day,
  output logic [4:0]  out_local_hour,
  output logic [5:0]  out_local_minute,
  output logic [5:0]  out_local_second,
  output logic [12:0] out_offset_seconds,
  output logic        out_summer_time
);

  localparam int DateLat = 7;
  localparam longint unsigned M3600 = ((64'd1 << 29) + 64'd3599) / 64'd3600;
  localparam longint unsigned M60   = ((64'd1 << 18) + 64'd59) / 64'd60;

  typedef struct packed {
    logic        ok;
    logic        dst;
    logic [12:0] off;
    logic [11:0] year;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [16:0] lsod;
    logic [4:0]  hour;
    logic [11:0] rem;
    logic [5:0]  minute;
  } stage_t;

  logic               en;
  utcl_item_t         side_r [DateLat];
  logic [DateLat-1:0] sv_r;
  logic [11:0]        uy, ly;
  logic [3:0]         um, lm;
  logic [4:0]         ud, ld;
  logic               v8_r, v9_r, v10_r, v11_r, v12_r;
  stage_t             p8_r, p9_r, p10_r, p11_r, p8_nxt;
  stage_t             p9_nxt, p10_nxt, p11_nxt;
  logic [34:0]        ph;
  logic [24:0]        pmin;
  logic [16:0]        hsecs;
  logic [11:0]        msecs;
  logic               passed, after, dst, wrap;
  logic [17:0]        lsod_raw;
  logic [16:0]        days_next;
  utcl_item_t         s6;

  // The back pipeline moves as a whole whenever the result register frees up.
  assign en        = !v12_r || out_ready;
  assign q_pop     = en && !q_empty;
  assign out_valid = v12_r;
  assign days_next = q_item.days + 17'd1;

  // Dates for the UTC day and for the following day, in parallel.
  utcl_date u_date_utc (
    .clk(clk), .en(en), .days_in(q_item.days), .year(uy), .month(um), .day(ud)
  );
  utcl_date u_date_next (
    .clk(clk), .en(en), .days_in(days_next), .year(ly), .month(lm), .day(ld)
  );

  // Daylight saving decision and local second of day.
  assign s6 = side_r[DateLat-1];
  always_comb begin
    passed   = ({1'b0, ud} >= ({3'b000, s6.wd} + 6'd25));
    after    = passed && ((s6.wd != 3'd0) || (s6.sod >= SecsPerHour));
    if ((um >= MonApr) && (um <= MonSep)) dst = 1'b1;
    else if (um == MonMar)                dst = after;
    else if (um == MonOct)                dst = !after;
    else                                  dst = 1'b0;
    p8_nxt     = '0;
    p8_nxt.dst = dst;
    p8_nxt.off = dst ? DstOffset : StdOffset;
    lsod_raw   = 18'(s6.sod) + 18'(p8_nxt.off);
    wrap       = (lsod_raw >= 18'(SecsPerDay));
    p8_nxt.lsod = wrap ? 17'(lsod_raw - 18'(SecsPerDay)) : 17'(lsod_raw);
    p8_nxt.ok   = s6.utc_ok && (!wrap || ((s6.days + 17'd1) < DaysPastValid));
    p8_nxt.year = wrap ? ly : uy;
    p8_nxt.mon  = wrap ? lm : um;
    p8_nxt.day  = wrap ? ld : ud;
  end

  assign ph    = 35'(p8_r.lsod) * 35'(M3600);
  assign hsecs = 17'(p9_r.hour) * SecsPerHour;
  assign pmin  = 25'(p10_r.rem) * 25'(M60);
  assign msecs = 12'(p11_r.minute) * 12'd60;

  // Hour, seconds into the hour and minute, one per stage.
  always_comb begin
    p9_nxt         = p8_r;
    p9_nxt.hour    = ph[29 +: 5];
    p10_nxt        = p9_r;
    p10_nxt.rem    = 12'(p9_r.lsod - hsecs);
    p11_nxt        = p10_r;
    p11_nxt.minute = pmin[18 +: 6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r  <= '0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
    end else if (en) begin
      sv_r  <= {sv_r[DateLat-2:0], q_pop};
      v8_r  <= sv_r[DateLat-1];
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Side data waits alongside the date converters.
      side_r[0] <= q_item;
      for (int k = 1; k < DateLat; k++) begin
        side_r[k] <= side_r[k-1];
      end
      p8_r  <= p8_nxt;
      p9_r  <= p9_nxt;
      p10_r <= p10_nxt;
      p11_r <= p11_nxt;
      // Result register; out-of-range results are all zero.
      out_valid_res      <= p11_r.ok;
      out_civil_year     <= p11_r.ok ? p11_r.year : '0;
      out_civil_month    <= p11_r.ok ? p11_r.mon : '0;
      out_civil_day      <= p11_r.ok ? p11_r.day : '0;
      out_local_hour     <= p11_r.ok ? p11_r.hour : '0;
      out_local_minute   <= p11_r.ok ? p11_r.minute : '0;
      out_local_second   <= p11_r.ok ? 6'(p11_r.rem - msecs) : '0;
      out_offset_seconds <= p11_r.ok ? p11_r.off : '0;
      out_summer_time    <= p11_r.ok && p11_r.dst;
    end
  end

endmodule

// ----- src/utc_to_local_civil_time_eu_dst.sv -----
`timescale 1ns / 1ps

// Converts a 33-bit UTC Unix timestamp into local civil time under the EU
// daylight saving rule (one hour offset in winter, two in summer, switching at
// 01:00 UTC on the last Sundays of March and October). One timestamp is taken
// per clock cycle while the queue has room, and results come out in order:
// three front stages find the day count, second of day and weekday, a queue
// of QUEUE_DEPTH entries follows, and twelve back stages run two seven-stage
// calendar converters side by side before the time of day is split out.
// Timestamps whose UTC date or local date lies outside the years 2000 to 2199
// are flagged invalid with all other fields zero.
module utc_to_local_civil_time_eu_dst import utcl_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [32:0] in_utc_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [11:0] out_civil_year,
  output logic [3:0]  out_civil_month,
  output logic [4:0]  out_civil_day,
  output logic [4:0]  out_local_hour,
  output logic [5:0]  out_local_minute,
  output logic [5:0]  out_local_second,
  output logic [12:0] out_offset_seconds,
  output logic        out_summer_time
);

  logic       q_full, q_push, q_empty, q_pop;
  utcl_item_t q_in, q_out;

  // Front end: timestamp split and classification.
  utcl_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_utc_seconds(in_utc_seconds),
    .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  // Decoupling queue.
  utcl_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .item_in(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .item_out(q_out)
  );

  // Back end: calendar conversion, daylight saving and time of day.
  utcl_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_pop(q_pop), .q_item(q_out),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_valid_res(out_valid_res), .out_civil_year(out_civil_year),
    .out_civil_month(out_civil_month), .out_civil_day(out_civil_day),
    .out_local_hour(out_local_hour), .out_local_minute(out_local_minute),
    .out_local_second(out_local_second), .out_offset_seconds(out_offset_seconds),
    .out_summer_time(out_summer_time)
  );

endmodule
